// ----- sv/atkinson_dither_stream_top_macros.svh -----
// Assertion macros shared by the checker of the Atkinson dither stream block.
`ifndef ATKINSON_DITHER_STREAM_TOP_MACROS_SVH
`define ATKINSON_DITHER_STREAM_TOP_MACROS_SVH

// Same-cycle implication, held off while reset is low.
`define ADS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off while reset is low.
`define ADS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/ads_pkg.sv -----
// Types and constants of the Atkinson dither stream block.
`timescale 1ns / 1ps
`default_nettype none

package ads_pkg;

    // Field and register widths
    localparam int PIX_W      = 8;
    localparam int ERR_W      = 5;
    localparam int ENT_W      = 2 * ERR_W;
    localparam int IMG_W_W    = 13;
    localparam int IMG_H_W    = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    // Register reset values
    localparam logic [IMG_W_W-1:0] IMAGE_WIDTH_RST  = 13'd640;
    localparam logic [IMG_H_W-1:0] IMAGE_HEIGHT_RST = 16'd480;

    // Pixel levels and quantiser
    localparam logic [PIX_W-1:0] THRESHOLD = 8'd128;
    localparam logic [PIX_W-1:0] PIX_WHITE = 8'hFF;
    localparam logic [PIX_W-1:0] PIX_BLACK = 8'h00;
    localparam int               ERR_SHIFT = 3;

    // Position flags of a pixel waiting in the compute stage
    typedef struct packed {
        logic y_ge1;
        logic y_ge2;
        logic x_ge1;
        logic x_ge2;
        logic has_right;
        logic eol;
        logic eof;
    } t_s1_ctl;

    // Add a signed error to a pixel, clamped to the pixel range
    function automatic logic [PIX_W-1:0] sat_add(input logic [PIX_W-1:0] v,
                                                 input logic signed [ERR_W-1:0] e);
        logic signed [PIX_W+1:0] s;
        s = signed'({2'b00, v}) + (PIX_W+2)'(e);
        if (s < 0) begin
            sat_add = PIX_BLACK;
        end else if (s > signed'({2'b00, PIX_WHITE})) begin
            sat_add = PIX_WHITE;
        end else begin
            sat_add = s[PIX_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

// ----- sv/ads_ifs.sv -----
// Stream and configuration interfaces of the Atkinson dither stream block.
`timescale 1ns / 1ps
`default_nettype none

// Grey pixel stream into the block
interface ads_pix_in_if
    import ads_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_in;

    modport source (output valid, output pixel_in, input ready);
    modport sink   (input valid, input pixel_in, output ready);
endinterface

// Dithered pixel stream out of the block
interface ads_pix_out_if
    import ads_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_out;
    logic             end_of_line;
    logic             end_of_frame;

    modport source (output valid, output pixel_out, output end_of_line,
                    output end_of_frame, input ready);
    modport sink   (input valid, input pixel_out, input end_of_line,
                    input end_of_frame, output ready);
endinterface

// Register write channel
interface ads_cfg_if
    import ads_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- sv/ads_ram.sv -----
// Generic RAM: one write port, two registered read ports, write-first on collision.
`timescale 1ns / 1ps
`default_nettype none

module ads_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    // Write, then read with the new word passed through on an address match
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata_a <= (i_we && (i_waddr == i_raddr_a)) ? i_wdata : r_mem[i_raddr_a];
            r_rdata_b <= (i_we && (i_waddr == i_raddr_b)) ? i_wdata : r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

`default_nettype wire

// ----- sv/atkinson_dither_stream_top.sv -----
// Atkinson dither stream: one grey pixel in, one black or white pixel out, raster order.
//
// Takes one pixel per clock with no bubbles while the output side is ready. The error
// row store is read at the edge that accepts a pixel. The compute stage then runs the
// chain of six saturating adds and the quantiser into the output register, from which
// the result can leave. The error rows live in one MAX_WIDTH-deep RAM holding the row
// above and the row two above side by side. It is read at columns x and x+1 as the
// pixel is accepted and written once per pixel; a just-written column is passed
// straight through to a read in the same cycle. The store is not cleared after reset
// and the block is ready at once. A shrink of image_width in mid-row ends the current
// row on the next pixel and, when no pixel leaves the compute stage in that cycle,
// puts back the row-above error of the last column that was reached.
`timescale 1ns / 1ps
`default_nettype none

module atkinson_dither_stream_top
    import ads_pkg::*;
#(
    parameter int MAX_WIDTH = 4096
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ads_cfg_if.sink       i_cfg,
    ads_pix_in_if.sink    i_pix,
    ads_pix_out_if.source o_pix
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int CMPW = (WW > IMG_W_W) ? WW : IMG_W_W;

    // Registers
    logic [IMG_W_W-1:0] r_img_w;
    logic [IMG_H_W-1:0] r_img_h;

    // Frame position of the next pixel
    logic [CW-1:0]      r_col;
    logic [IMG_H_W-1:0] r_row;

    // Compute stage
    logic                     r_s1_vld;
    logic [PIX_W-1:0]         r_s1_pix;
    logic [CW-1:0]            r_s1_x;
    t_s1_ctl                  r_s1_ctl;
    logic signed [ERR_W-1:0]  r_above_l;
    logic signed [ERR_W-1:0]  r_left_one;
    logic signed [ERR_W-1:0]  r_left_two;

    // Output register
    logic             r_out_vld;
    logic [PIX_W-1:0] r_out_pix;
    logic             r_out_eol;
    logic             r_out_eof;

    // Accept side
    logic               in_acc;
    logic               s1_adv;
    logic [CMPW-1:0]    w_ext;
    logic [WW-1:0]      w_eff;
    logic [IMG_H_W-1:0] h_eff;
    logic               col_over;
    logic [CW-1:0]      x;
    logic [WW-1:0]      x_inc;
    logic [IMG_H_W:0]   y_pre;
    logic [IMG_H_W-1:0] y;
    logic               eol;
    logic               eof;
    t_s1_ctl            n_ctl;

    // Error store ports
    logic             ram_we;
    logic [CW-1:0]    ram_waddr;
    logic [ENT_W-1:0] ram_wdata;
    logic [ENT_W-1:0] ram_rd_a;
    logic [ENT_W-1:0] ram_rd_b;

    // Compute results
    logic signed [ERR_W-1:0] above_c;
    logic signed [ERR_W-1:0] above_r;
    logic signed [ERR_W-1:0] two_above;
    logic [PIX_W-1:0]        v;
    logic [PIX_W-1:0]        nv;
    logic signed [PIX_W:0]   diff;
    logic signed [ERR_W-1:0] err;

    // Configuration: always ready; to be written only while idle, which the block does not enforce
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w <= IMAGE_WIDTH_RST;
            r_img_h <= IMAGE_HEIGHT_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_IMAGE_WIDTH:  r_img_w <= i_cfg.data[IMG_W_W-1:0];
                REG_IMAGE_HEIGHT: r_img_h <= i_cfg.data[IMG_H_W-1:0];
                default:          r_img_w <= r_img_w;
            endcase
        end
    end

    // Handshakes
    assign s1_adv      = r_s1_vld && (!r_out_vld || o_pix.ready);
    assign i_pix.ready = !r_s1_vld || s1_adv;
    assign in_acc      = i_pix.valid && i_pix.ready;

    // Clamp the frame width to what the store holds, and a zero width or height to one
    always_comb begin
        w_ext = CMPW'(r_img_w);
        if (w_ext == '0) begin
            w_eff = WW'(1);
        end else if (w_ext > CMPW'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = w_ext[WW-1:0];
        end
        h_eff = (r_img_h == '0) ? IMG_H_W'(1) : r_img_h;
    end

    // Place the incoming pixel, wrapping a row that the width no longer holds
    always_comb begin
        col_over = (WW'(r_col) >= w_eff);
        x        = col_over ? '0 : r_col;
        y_pre    = col_over ? ({1'b0, r_row} + (IMG_H_W+1)'(1)) : {1'b0, r_row};
        y        = (y_pre >= {1'b0, h_eff}) ? '0 : y_pre[IMG_H_W-1:0];
        x_inc    = WW'(x) + WW'(1);
        eol      = (x_inc == w_eff);
        eof      = eol && (({1'b0, y} + (IMG_H_W+1)'(1)) == {1'b0, h_eff});

        n_ctl.y_ge1     = (y != '0);
        n_ctl.y_ge2     = (y[IMG_H_W-1:1] != '0);
        n_ctl.x_ge1     = (x != '0);
        n_ctl.x_ge2     = (x[CW-1:1] != '0);
        n_ctl.has_right = !eol;
        n_ctl.eol       = eol;
        n_ctl.eof       = eof;
    end

    // Advance the position on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_acc) begin
            if (eol) begin
                r_col <= '0;
                r_row <= eof ? '0 : (y + IMG_H_W'(1));
            end else begin
                r_col <= x_inc[CW-1:0];
                r_row <= y;
            end
        end
    end

    // Load the compute stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (in_acc) begin
            r_s1_vld <= 1'b1;
        end else if (s1_adv) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_pix <= i_pix.pixel_in;
            r_s1_x   <= x;
            r_s1_ctl <= n_ctl;
        end
    end

    // Error store write: the finished pixel, or the put-back on a cut-short row
    always_comb begin
        if (s1_adv) begin
            ram_we    = 1'b1;
            ram_waddr = r_s1_x;
            ram_wdata = {err, above_c};
        end else begin
            ram_we    = in_acc && col_over;
            ram_waddr = r_col - CW'(1);
            ram_wdata = {r_above_l, r_above_l};
        end
    end

    ads_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_WIDTH)
    ) u_err_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_re      (in_acc),
        .i_raddr_a (x),
        .i_raddr_b (x_inc[CW-1:0]),
        .o_rdata_a (ram_rd_a),
        .o_rdata_b (ram_rd_b)
    );

    // Diffuse the pending errors, quantise, form the new error
    always_comb begin
        above_c   = ram_rd_a[ENT_W-1:ERR_W];
        two_above = ram_rd_a[ERR_W-1:0];
        above_r   = ram_rd_b[ENT_W-1:ERR_W];

        v = r_s1_pix;
        if (r_s1_ctl.y_ge2) begin
            v = sat_add(v, two_above);
        end
        if (r_s1_ctl.y_ge1) begin
            if (r_s1_ctl.x_ge1) begin
                v = sat_add(v, r_above_l);
            end
            v = sat_add(v, above_c);
            if (r_s1_ctl.has_right) begin
                v = sat_add(v, above_r);
            end
        end
        if (r_s1_ctl.x_ge2) begin
            v = sat_add(v, r_left_two);
        end
        if (r_s1_ctl.x_ge1) begin
            v = sat_add(v, r_left_one);
        end

        nv   = (v >= THRESHOLD) ? PIX_WHITE : PIX_BLACK;
        diff = signed'({1'b0, v}) - signed'({1'b0, nv});
        err  = ERR_W'(diff >>> ERR_SHIFT);
    end

    // Slide the error window as a pixel leaves the compute stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_one <= '0;
            r_left_two <= '0;
        end else if (s1_adv) begin
            r_left_two <= r_left_one;
            r_left_one <= err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_above_l <= above_c;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_adv) begin
            r_out_vld <= 1'b1;
        end else if (o_pix.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_pix <= nv;
            r_out_eol <= r_s1_ctl.eol;
            r_out_eof <= r_s1_ctl.eof;
        end
    end

    assign o_pix.valid        = r_out_vld;
    assign o_pix.pixel_out    = r_out_pix;
    assign o_pix.end_of_line  = r_out_eol;
    assign o_pix.end_of_frame = r_out_eof;

endmodule

`default_nettype wire

// ----- sv/ads_chk.sv -----
// Port checker of the Atkinson dither stream block and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "atkinson_dither_stream_top_macros.svh"

module ads_chk
    import ads_pkg::*;
(
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_in_ready,
    input wire logic             i_out_valid,
    input wire logic             i_out_ready,
    input wire logic [PIX_W-1:0] i_pixel_out,
    input wire logic             i_end_of_line,
    input wire logic             i_end_of_frame
);

    // Every result beat is pure black or pure white
    `ADS_ASSERT_SAME(a_pix_binary, i_clk, i_rst_n, i_out_valid, (i_pixel_out == PIX_WHITE) || (i_pixel_out == PIX_BLACK), "dithered pixel is neither black nor white")

    // A frame ends only on the last pixel of a row
    `ADS_ASSERT_SAME(a_eof_on_eol, i_clk, i_rst_n, i_out_valid && i_end_of_frame, i_end_of_line, "end of frame without end of line")

    // With the output register empty the input side must take a beat
    `ADS_ASSERT_SAME(a_room_when_empty, i_clk, i_rst_n, !i_out_valid, i_in_ready, "input stalled while output register is empty")

    // Hold a stalled result beat
    `ADS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_pixel_out) && $stable(i_end_of_line) && $stable(i_end_of_frame), "stalled result beat changed")

endmodule

bind atkinson_dither_stream_top ads_chk u_ads_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_ready     (i_pix.ready),
    .i_out_valid    (o_pix.valid),
    .i_out_ready    (o_pix.ready),
    .i_pixel_out    (o_pix.pixel_out),
    .i_end_of_line  (o_pix.end_of_line),
    .i_end_of_frame (o_pix.end_of_frame)
);

`default_nettype wire
